>>> rtl/irst_pkg.sv
package irst_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned SlotWidth  = 6;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [SlotWidth-1:0] slot_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVERTED = 3'd1,
    ST_OVERLAP  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // one stored interval as it moves along the ring of cells
  typedef struct packed {
    logic   valid;
    coord_t left;
    coord_t right;
    coord_t level;
  } entry_t;

  // result fields, status in the lowest bits
  typedef struct packed {
    coord_t  hit_level;
    coord_t  hit_right;
    coord_t  hit_left;
    slot_t   hit_slot;
    logic    found;
    status_e status;
  } result_t;
endpackage

>>> rtl/interval_ray_shooting_table_core.sv
// Operation: an accepted request runs a scan (one full turn of the cell ring),
// then a commit step registers the result. One request is handled at a time:
// the next request is taken once the result is registered, and a result still
// waiting holds the next commit.
// Reset: rst_ni clears every valid bit, so the table starts empty; the interval
// fields of the cells are not reset.
module interval_ray_shooting_table_core import irst_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: left_end[31:0], right_end[63:32], level[95:64], probe_x[127:96],
  //        upward[128], slot_index[134:129], zero fill to 136 bits
  input  logic [135:0] s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[2:0], found[3], hit_slot[9:4], hit_left[41:10],
  //        hit_right[73:42], hit_level[105:74], zero fill to 112 bits
  output logic [111:0] m_axis_tdata
);
  // The ring of TableDepth cells rotates by one each scan cycle; cell 0 at
  // scan step k holds slot k. After a full turn every slot is home again.

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  entry_t                cell_q [TableDepth];
  logic [TableDepth-1:0] load_en;
  entry_t                load_entry;
  logic                  shift;
  logic                  tail_load;
  logic                  ins_load;

  // control
  state_e state_q, state_d;
  slot_t  step_q;
  logic   out_valid_q, out_valid_d;

  // request registers
  kind_e  kind_q;
  coord_t l_q, r_q, z_q, x_q;
  logic   up_q;
  slot_t  idx_q;

  // scan results
  logic   have_q, overlap_q, free_q;
  slot_t  best_q, free_slot_q;
  entry_t best_e_q;

  // output register
  result_t out_q, res;

  entry_t head;
  slot_t  cur;
  logic   hit, better, ovl, last, accept, commit, inverted;

  // Each cell takes its upper neighbor while shifting. The tail cell can load
  // the passing head instead (delete), and the free slot's cell loads the new
  // interval during the commit cycle, when the ring is back home.
  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    assign load_en[i] = (tail_load && (i == TableDepth - 1)) ||
                        (ins_load && free_slot_q == SlotWidth'(i));
    irst_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (load_en[i]),
      .load_entry_i (load_entry),
      .shift_i      (shift),
      .prev_i       (cell_q[(i + 1) % TableDepth]),
      .entry_o      (cell_q[i])
    );
  end

  assign head     = cell_q[0];
  assign cur      = step_q;
  assign last     = (step_q == slot_t'(TableDepth - 1));
  assign shift    = (state_q == S_SCAN);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign commit   = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign inverted = (l_q > r_q);

  // delete: clear the valid bit as the named slot passes the head
  assign tail_load = shift && kind_q == KIND_DELETE && cur == idx_q && head.valid;
  // insert: written only when no check failed
  assign ins_load  = commit && kind_q == KIND_INSERT && !inverted && !overlap_q && free_q;

  always_comb begin
    load_entry = head;
    if (ins_load) begin
      load_entry = '{valid: 1'b1, left: l_q, right: r_q, level: z_q};
    end else begin
      load_entry.valid = 1'b0;
    end
  end

  // per-slot tests on the head cell; strict compares keep the lowest slot on ties
  always_comb begin
    hit = head.valid &&
          ((x_q >= head.left && x_q < head.right) ||
           (x_q == head.right && head.right == head.left));
    better = 1'b0;
    if (up_q) begin
      better = hit && head.level > z_q && (!have_q || head.level < best_e_q.level);
    end else begin
      better = hit && head.level < z_q && (!have_q || head.level > best_e_q.level);
    end
    ovl = head.valid && head.level == z_q && !(l_q >= head.right || r_q <= head.left);
  end

  // result; checks in priority order, unset fields stay zero
  always_comb begin
    res = '0;
    case (kind_q)
      KIND_INSERT: begin
        if (inverted) begin
          res.status = ST_INVERTED;
        end else if (overlap_q) begin
          res.status = ST_OVERLAP;
        end else if (!free_q) begin
          res.status = ST_FULL;
        end else begin
          res.found     = 1'b1;
          res.hit_slot  = free_slot_q;
          res.hit_left  = l_q;
          res.hit_right = r_q;
          res.hit_level = z_q;
        end
      end
      KIND_DELETE: begin
        if (!have_q) begin
          res.status = ST_EMPTY;
        end else begin
          res.hit_slot  = idx_q;
          res.hit_left  = best_e_q.left;
          res.hit_right = best_e_q.right;
          res.hit_level = best_e_q.level;
        end
      end
      KIND_QUERY: begin
        if (have_q) begin
          res.found     = 1'b1;
          res.hit_slot  = best_q;
          res.hit_left  = best_e_q.left;
          res.hit_right = best_e_q.right;
          res.hit_level = best_e_q.level;
        end
      end
      default: res = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (last) state_d = S_DONE;
      end
      S_DONE: begin
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // a new request only while idle; a waiting result does not block it
  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      // wraps back to zero at the end of a scan
      if (shift) step_q <= step_q + slot_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= kind_e'(s_axis_tuser);
      l_q         <= s_axis_tdata[31:0];
      r_q         <= s_axis_tdata[63:32];
      z_q         <= s_axis_tdata[95:64];
      x_q         <= s_axis_tdata[127:96];
      up_q        <= s_axis_tdata[128];
      idx_q       <= s_axis_tdata[134:129];
      have_q      <= 1'b0;
      overlap_q   <= 1'b0;
      free_q      <= 1'b0;
      best_q      <= '0;
      free_slot_q <= '0;
    end else if (shift) begin
      case (kind_q)
        KIND_INSERT: begin
          if (ovl) overlap_q <= 1'b1;
          if (!head.valid && !free_q) begin
            free_q      <= 1'b1;
            free_slot_q <= cur;
          end
        end
        KIND_DELETE: begin
          if (tail_load) begin
            have_q   <= 1'b1;
            best_e_q <= head;
          end
        end
        KIND_QUERY: begin
          if (better) begin
            have_q   <= 1'b1;
            best_q   <= cur;
            best_e_q <= head;
          end
        end
        default: ;
      endcase
    end else if (commit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};
endmodule

>>> rtl/irst_cell.sv
module irst_cell import irst_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  entry_t load_entry_i,
  input  logic   shift_i,
  input  entry_t prev_i,
  output entry_t entry_o
);
  logic   valid_q;
  coord_t left_q, right_q, level_q;
  entry_t cur_entry, entry_d;

  assign cur_entry = '{valid: valid_q, left: left_q, right: right_q, level: level_q};

  always_comb begin
    entry_d = cur_entry;
    if (load_i) begin
      entry_d = load_entry_i;
    end else if (shift_i) begin
      entry_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= entry_d.left;
    right_q <= entry_d.right;
    level_q <= entry_d.level;
  end

  assign entry_o = cur_entry;
endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import irst_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;

  interval_ray_shooting_table_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // status in the lowest bits
  typedef struct packed {
    coord_t     hit_level;
    coord_t     hit_right;
    coord_t     hit_left;
    slot_t      hit_slot;
    logic       found;
    logic [2:0] status;
  } answer_t;

  // shadow table
  logic   tbl_valid [TableDepth];
  coord_t tbl_left  [TableDepth];
  coord_t tbl_right [TableDepth];
  coord_t tbl_level [TableDepth];

  answer_t answer_q[$];
  int      n_mismatch;
  int      idle_cycles;
  bit      timed_out;
  int      send_gap_pct;
  int      stall_pct;
  bit      hold_off;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void fill_hit(inout answer_t a, input int s);
    a.hit_slot  = slot_t'(s);
    a.hit_left  = tbl_left[s];
    a.hit_right = tbl_right[s];
    a.hit_level = tbl_level[s];
  endfunction

  // Advances the shadow table and returns the response for one request.
  function automatic answer_t table_response(kind_e kind, coord_t l, coord_t r, coord_t z,
                                             coord_t x, logic up, slot_t idx);
    answer_t a;
    int      free_slot;
    int      best;
    a = '0;
    best = -1;
    free_slot = -1;
    case (kind)
      KIND_INSERT: begin
        if (l > r) begin
          a.status = ST_INVERTED;
          return a;
        end
        for (int s = 0; s < TableDepth; s++) begin
          if (!tbl_valid[s]) begin
            if (free_slot < 0) free_slot = s;
          end else if (tbl_level[s] == z && !(l >= tbl_right[s] || r <= tbl_left[s])) begin
            a.status = ST_OVERLAP;
            return a;
          end
        end
        if (free_slot < 0) begin
          a.status = ST_FULL;
          return a;
        end
        tbl_valid[free_slot] = 1'b1;
        tbl_left[free_slot]  = l;
        tbl_right[free_slot] = r;
        tbl_level[free_slot] = z;
        a.status = ST_OK;
        a.found  = 1'b1;
        fill_hit(a, free_slot);
      end
      KIND_DELETE: begin
        if (int'(idx) >= TableDepth || !tbl_valid[idx]) begin
          a.status = ST_EMPTY;
          return a;
        end
        tbl_valid[idx] = 1'b0;
        fill_hit(a, idx);
      end
      KIND_QUERY: begin
        for (int s = 0; s < TableDepth; s++) begin
          if (!tbl_valid[s]) continue;
          if (!((x >= tbl_left[s] && x < tbl_right[s]) ||
                (x == tbl_right[s] && tbl_right[s] == tbl_left[s]))) continue;
          if (up) begin
            if (tbl_level[s] > z && (best < 0 || tbl_level[s] < tbl_level[best])) best = s;
          end else begin
            if (tbl_level[s] < z && (best < 0 || tbl_level[s] > tbl_level[best])) best = s;
          end
        end
        if (best >= 0) begin
          a.found = 1'b1;
          fill_hit(a, best);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_request(kind_e kind, coord_t l, coord_t r, coord_t z,
                              coord_t x = '0, logic up = 1'b0, slot_t idx = '0);
    while ($urandom_range(99) < send_gap_pct) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {1'b0, idx, up, x, z, r, l};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    answer_q = {answer_q, table_response(kind, l, r, z, x, up, idx)};
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (answer_q.size() != 0 && !timed_out) @(negedge clk_i);
  endtask

  // receiver stall pattern, plus an optional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = answer_t'(m_axis_tdata[105:0]);
      if (answer_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected response %h", got);
      end else begin
        want = answer_q.pop_front();
        if (got !== want || m_axis_tdata[111:106] !== '0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"mismatch: exp st=%0d f=%0d sl=%0d l=%h r=%h z=%h",
                      " got st=%0d f=%0d sl=%0d l=%h r=%h z=%h"},
                     want.status, want.found, want.hit_slot, want.hit_left, want.hit_right,
                     want.hit_level, got.status, got.found, got.hit_slot, got.hit_left,
                     got.hit_right, got.hit_level);
        end
      end
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1'b1;
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic coord_t rnd_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(40) - 20) <<< 16;
      default: return coord_t'($signed($urandom_range(16)) - 8);
    endcase
  endfunction

  task automatic test_directed();
    coord_t mn, mx;
    mn = {1'b1, {(CoordWidth-1){1'b0}}};
    mx = {1'b0, {(CoordWidth-1){1'b1}}};
    send_gap_pct = 0;
    stall_pct    = 0;
    send_request(KIND_QUERY, '0, '0, '0, '0, 1'b1);          // empty table
    send_request(KIND_INSERT, mx, mn, '0);                   // inverted ends
    send_request(KIND_INSERT, mn, mx, '0);                   // full span
    send_request(KIND_INSERT, '0, 32'sd5, '0);               // overlap
    send_request(KIND_INSERT, mn, mx, mx);
    send_request(KIND_INSERT, mn, mx, mn);
    send_request(KIND_INSERT, 32'sd7, 32'sd7, 32'sd10);      // point interval
    send_request(KIND_INSERT, 32'sd7, 32'sd7, 32'sd10);      // point vs point: no overlap
    send_request(KIND_QUERY, '0, '0, '0, 32'sd7, 1'b1);
    send_request(KIND_QUERY, '0, '0, mx, 32'sd7, 1'b0);
    send_request(KIND_QUERY, '0, '0, '0, mx, 1'b1);          // right end excluded
    send_request(KIND_QUERY, '0, '0, mn, mn, 1'b0);          // nothing strictly below
    send_request(KIND_QUERY, '0, '0, '0, mn, 1'b0);
    send_request(KIND_DELETE, '0, '0, '0, '0, 1'b0, 6'd63);  // empty slot
    send_request(KIND_DELETE, '0, '0, '0, '0, 1'b0, 6'd0);
    send_request(KIND_DELETE, '0, '0, '0, '0, 1'b0, 6'd0);   // already free
    send_request(KIND_INSERT, 32'sd1, 32'sd2, '0);           // reuses slot 0
    send_request(KIND_NONE, mx, mx, mx, mx, 1'b1, 6'd63);
    wait_drained();
  endtask

  task automatic test_fill_table();
    // fill to full, check full status, then free some
    for (int i = 0; i < TableDepth + 2; i++)
      send_request(KIND_INSERT, coord_t'(i), coord_t'(i + 1), 32'sd1000);
    for (int i = 0; i < 8; i++)
      send_request(KIND_DELETE, '0, '0, '0, '0, 1'b0, slot_t'($urandom_range(63)));
    wait_drained();
  endtask

  task automatic test_random(int n, int gap, int stall);
    coord_t l, r;
    int     k;
    send_gap_pct = gap;
    stall_pct    = stall;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      l = rnd_coord();
      r = rnd_coord();
      if (k < 4) begin
        if ($urandom_range(9) != 0 && l > r) {l, r} = {r, l};
        send_request(KIND_INSERT, l, r, rnd_coord());
      end else if (k < 6) begin
        send_request(KIND_DELETE, '0, '0, '0, '0, 1'b0, slot_t'($urandom));
      end else if (k < 9) begin
        send_request(KIND_QUERY, '0, '0, rnd_coord(), rnd_coord(), 1'($urandom));
      end else begin
        send_request(KIND_NONE, l, r, coord_t'($urandom), coord_t'($urandom),
                     1'($urandom), slot_t'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    stall_pct    = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk_i);
        hold_off = 1'b0;
      end
      test_random(6, 0, 0);
    join
    wait_drained();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_NONE;
    m_axis_tready = 1'b0;
    n_mismatch    = 0;
    idle_cycles   = 0;
    timed_out     = 1'b0;
    hold_off      = 1'b0;
    send_gap_pct  = 0;
    stall_pct     = 0;
    for (int s = 0; s < TableDepth; s++) begin
      tbl_valid[s] = 1'b0;
      tbl_left[s]  = '0;
      tbl_right[s] = '0;
      tbl_level[s] = '0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_fill_table();
    test_random(110, 0, 0);
    test_random(110, 57, 0);
    test_backpressure();
    test_random(110, 0, 57);
    test_random(110, 10, 10);
    wait_drained();
    repeat (3 * TableDepth) @(negedge clk_i);

    if (n_mismatch == 0 && answer_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/irst_pkg.sv
rtl/irst_cell.sv
rtl/interval_ray_shooting_table_core.sv
dv/tb.sv
